FILE: rtl/core/pisu_pkg.sv
package pisu_pkg;

   localparam int MAX_SPHERES = 256;
   localparam int COORD_BITS  = 24;
   localparam int RAD_BITS    = COORD_BITS - 1;
   localparam int IDX_BITS    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int COUNT_BITS  = $clog2(MAX_SPHERES + 1);
   localparam int BOX_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * COORD_BITS;
   localparam int ACC_BITS    = PROD_BITS + 2;
   localparam int ENTRY_BITS  = RAD_BITS + 3 * COORD_BITS;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_ADD   = 2'd1;
   localparam logic [1:0] REQ_QUERY = 2'd2;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } vec3_type;

   typedef struct packed {
      logic [1:0]          req_type;
      coord_type           pos_x;
      coord_type           pos_y;
      coord_type           pos_z;
      logic [RAD_BITS-1:0] sphere_radius;
   } req_item_type;

   typedef struct packed {
      logic                  inside_res;
      logic                  status;
      logic [COUNT_BITS-1:0] sphere_count;
   } rsp_item_type;

   typedef enum logic [1:0] {
      OP_DX,
      OP_DY,
      OP_DZ,
      OP_RAD
   } dist_op_type;

   typedef struct packed {
      logic        mul_en;
      dist_op_type op;
   } dist_ctl_type;

   typedef struct packed {
      logic clear;
      logic grow;
   } box_ctl_type;

endpackage

FILE: rtl/core/pisu_ram.sv
module pisu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/pisu_box.sv
module pisu_box (
   input  logic                  clock,
   input  logic                  reset,
   input  pisu_pkg::box_ctl_type ctl,
   input  pisu_pkg::vec3_type    pos,
   input  logic [pisu_pkg::RAD_BITS-1:0] radius,
   output logic                  in_box
);
   import pisu_pkg::*;

   localparam logic signed [BOX_BITS-1:0] BOX_MAX = {1'b0, {(BOX_BITS-1){1'b1}}};
   localparam logic signed [BOX_BITS-1:0] BOX_MIN = {1'b1, {(BOX_BITS-1){1'b0}}};

   logic signed [BOX_BITS-1:0] low_ff  [3];
   logic signed [BOX_BITS-1:0] high_ff [3];
   logic signed [BOX_BITS-1:0] low_in  [3];
   logic signed [BOX_BITS-1:0] high_in [3];
   logic signed [BOX_BITS-1:0] p_ext   [3];
   logic signed [BOX_BITS-1:0] lo_cand [3];
   logic signed [BOX_BITS-1:0] hi_cand [3];
   logic signed [BOX_BITS-1:0] r_ext;
   logic [2:0]                 axis_ok;

   assign p_ext[0] = BOX_BITS'(pos.x);
   assign p_ext[1] = BOX_BITS'(pos.y);
   assign p_ext[2] = BOX_BITS'(pos.z);
   assign r_ext    = $signed({{(BOX_BITS-RAD_BITS){1'b0}}, radius});

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lo_cand[k] = p_ext[k] - r_ext;
         hi_cand[k] = p_ext[k] + r_ext;
         low_in[k]  = low_ff[k];
         high_in[k] = high_ff[k];
         if (ctl.clear) begin
            low_in[k]  = BOX_MAX;
            high_in[k] = BOX_MIN;
         end else if (ctl.grow) begin
            if (lo_cand[k] < low_ff[k]) begin
               low_in[k] = lo_cand[k];
            end
            if (hi_cand[k] > high_ff[k]) begin
               high_in[k] = hi_cand[k];
            end
         end
         axis_ok[k] = (p_ext[k] >= low_ff[k]) && (p_ext[k] <= high_ff[k]);
      end
   end

   assign in_box = &axis_ok;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         if (reset) begin
            low_ff[k]  <= BOX_MAX;
            high_ff[k] <= BOX_MIN;
         end else begin
            low_ff[k]  <= low_in[k];
            high_ff[k] <= high_in[k];
         end
      end
   end

endmodule

FILE: rtl/core/pisu_dist_unit.sv
module pisu_dist_unit (
   input  logic                   clock,
   input  pisu_pkg::dist_ctl_type ctl,
   input  pisu_pkg::vec3_type     point,
   input  pisu_pkg::vec3_type     center,
   input  logic [pisu_pkg::RAD_BITS-1:0] radius,
   output logic                   hit
);
   import pisu_pkg::*;

   logic signed [COORD_BITS:0] diff;
   logic signed [COORD_BITS:0] mag;
   logic [COORD_BITS-1:0]      operand;
   logic [PROD_BITS-1:0]       prod_ff;
   logic [PROD_BITS-1:0]       prod_in;
   logic [ACC_BITS-1:0]        acc_ff;
   logic [ACC_BITS-1:0]        acc_in;
   coord_type                  p_sel;
   coord_type                  c_sel;

   // one axis per step, radius on the last step
   always_comb begin
      case (ctl.op)
         OP_DX:   begin p_sel = point.x; c_sel = center.x; end
         OP_DY:   begin p_sel = point.y; c_sel = center.y; end
         default: begin p_sel = point.z; c_sel = center.z; end
      endcase
      diff = (COORD_BITS+1)'(p_sel) - (COORD_BITS+1)'(c_sel);
      mag  = diff[COORD_BITS] ? -diff : diff;
      if (ctl.op == OP_RAD) begin
         operand = {{(COORD_BITS-RAD_BITS){1'b0}}, radius};
      end else begin
         operand = mag[COORD_BITS-1:0];
      end
   end

   // product is registered, summed on the next step
   always_comb begin
      prod_in = prod_ff;
      acc_in  = acc_ff;
      if (ctl.mul_en) begin
         prod_in = PROD_BITS'(operand) * PROD_BITS'(operand);
         case (ctl.op)
            OP_DX:   acc_in = acc_ff;
            OP_DY:   acc_in = ACC_BITS'(prod_ff);
            default: acc_in = acc_ff + ACC_BITS'(prod_ff);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // valid once the radius square sits in the product register
   assign hit = acc_ff <= ACC_BITS'(prod_ff);

endmodule

FILE: rtl/core/point_in_sphere_union.sv
// channel   dir  handshake              word
// req       in   req_valid / req_stall  req_data  (clear, add sphere, query point)
// rsp       out  rsp_valid / rsp_stall  rsp_data  (inside flag, status, sphere count)
//
// clear and add: straight from accept to S_DONE, then to the result register
// query outside the box or on an empty table: also straight from accept to S_DONE
// query inside the box: S_MUL then S_CMP for each of n spheres tested, n up to 256;
//   the single squaring multiplier is used four times per sphere plus one compare
// reset is synchronous; it empties the table and the box, no memory sweep
// a new word is taken while an earlier result still waits on rsp_stall
module point_in_sphere_union (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pisu_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pisu_pkg::rsp_item_type rsp_data
);
   import pisu_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_CMP,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   dist_op_type           op_ff, op_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   vec3_type              point_ff, point_in;
   rsp_item_type          res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_data_ff, rsp_data_in;

   logic                  req_take;
   logic [COUNT_BITS-1:0] idx_next;
   vec3_type              req_pos;

   // table port signals
   logic                  ram_we;
   logic                  ram_re;
   logic [IDX_BITS-1:0]   ram_raddr;
   logic [ENTRY_BITS-1:0] ram_wdata;
   logic [ENTRY_BITS-1:0] ram_rdata;
   vec3_type              ent_center;
   logic [RAD_BITS-1:0]   ent_radius;

   box_ctl_type           box_ctl;
   logic                  in_box;
   dist_ctl_type          dist_ctl;
   logic                  hit;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign req_pos.x = req_data.pos_x;
   assign req_pos.y = req_data.pos_y;
   assign req_pos.z = req_data.pos_z;

   assign ram_wdata  = {req_data.sphere_radius, req_pos};
   assign ent_center = ram_rdata[3*COORD_BITS-1:0];
   assign ent_radius = ram_rdata[ENTRY_BITS-1:3*COORD_BITS];

   assign idx_next = COUNT_BITS'(idx_ff) + COUNT_BITS'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      point_in     = point_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = idx_ff;
      box_ctl      = '0;
      dist_ctl     = '{mul_en: 1'b0, op: op_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               res_in   = '0;
               state_in = S_DONE;
               case (req_data.req_type)
                  REQ_CLEAR: begin
                     count_in      = '0;
                     box_ctl.clear = 1'b1;
                  end
                  REQ_ADD: begin
                     if (count_ff == COUNT_BITS'(MAX_SPHERES)) begin
                        res_in.status = 1'b1;
                     end else begin
                        ram_we       = 1'b1;
                        box_ctl.grow = 1'b1;
                        count_in     = count_ff + COUNT_BITS'(1);
                     end
                  end
                  REQ_QUERY: begin
                     point_in = req_pos;
                     // early out on the bounding box and on an empty table
                     if (in_box && (count_ff != '0)) begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        idx_in    = '0;
                        op_in     = OP_DX;
                        state_in  = S_MUL;
                     end
                  end
                  default: begin
                  end
               endcase
               res_in.sphere_count = count_in;
            end
         end
         S_MUL: begin
            dist_ctl.mul_en = 1'b1;
            unique case (op_ff)
               OP_DX:  op_in = OP_DY;
               OP_DY:  op_in = OP_DZ;
               OP_DZ:  op_in = OP_RAD;
               OP_RAD: begin
                  op_in    = OP_DX;
                  state_in = S_CMP;
               end
            endcase
         end
         S_CMP: begin
            if (hit) begin
               res_in.inside_res = 1'b1;
               state_in          = S_DONE;
            end else if (idx_next == count_ff) begin
               state_in = S_DONE;
            end else begin
               // fetch the next sphere while deciding
               idx_in    = idx_next[IDX_BITS-1:0];
               ram_re    = 1'b1;
               ram_raddr = idx_next[IDX_BITS-1:0];
               state_in  = S_MUL;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_DX;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      point_ff    <= point_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sphere table: center and radius side by side
   pisu_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_SPHERES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[IDX_BITS-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   pisu_box u_box (
      .clock  (clock),
      .reset  (reset),
      .ctl    (box_ctl),
      .pos    (req_pos),
      .radius (req_data.sphere_radius),
      .in_box (in_box)
   );

   pisu_dist_unit u_dist (
      .clock  (clock),
      .ctl    (dist_ctl),
      .point  (point_ff),
      .center (ent_center),
      .radius (ent_radius),
      .hit    (hit)
   );

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_SPHERES))
      else $error("sphere count beyond table size");

   a_read_written: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_CMP) |-> (COUNT_BITS'(idx_ff) < count_ff))
      else $error("search index past stored spheres");

   a_sphere_starts_dx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && $past(state_ff) != S_MUL) |-> (op_ff == OP_DX))
      else $error("sphere test did not start on the x axis");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result word raised outside the done state");

   a_no_write_in_search: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (!ram_we && !box_ctl.clear && !box_ctl.grow))
      else $error("table or box changed during a search");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import pisu_pkg::*;

   // request code with no meaning, the block must ignore it
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int COORD_MAX = 2 ** (COORD_BITS - 1) - 1;
   localparam int COORD_MIN = -(2 ** (COORD_BITS - 1));
   localparam int RAD_MAX   = 2 ** RAD_BITS - 1;

   // the drain wait covers a full-table query that walks every entry
   localparam int DRAIN_CYCLES = 2 + 5 * MAX_SPHERES + 20;
   // cycles with no word moving on either channel before giving up
   localparam int STUCK_LIMIT  = 20000;

   // tracks the sphere table and box, and holds the answers still owed
   class sphere_union_tracker;
      coord_type                  center_tab[MAX_SPHERES][3];
      logic [RAD_BITS-1:0]        radius_tab[MAX_SPHERES];
      logic [COUNT_BITS-1:0]      n_spheres;
      logic signed [BOX_BITS-1:0] box_lo[3];
      logic signed [BOX_BITS-1:0] box_hi[3];
      rsp_item_type               owed_answers[$];
      int                         errors;
      int                         checked;

      function new();
         n_spheres = '0;
         errors    = 0;
         checked   = 0;
         empty_box();
      endfunction

      function void empty_box();
         for (int k = 0; k < 3; k++) begin
            box_lo[k] = {1'b0, {(BOX_BITS - 1){1'b1}}};
            box_hi[k] = {1'b1, {(BOX_BITS - 1){1'b0}}};
         end
      endfunction

      function logic [ACC_BITS-1:0] dist_sq(coord_type a, coord_type b);
         logic signed [COORD_BITS:0] d;
         logic [ACC_BITS-1:0]        m;
         d = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
         if (d < 0) d = -d;
         m = ACC_BITS'(d);
         return m * m;
      endfunction

      function rsp_item_type answer_for(req_item_type w);
         rsp_item_type               r;
         coord_type                  p[3];
         logic signed [BOX_BITS-1:0] lo;
         logic signed [BOX_BITS-1:0] hi;
         logic signed [BOX_BITS-1:0] rad_s;
         logic [ACC_BITS-1:0]        d2;
         logic [ACC_BITS-1:0]        rad;
         bit                         in_box;
         int                         i;
         r     = '0;
         p[0]  = w.pos_x;
         p[1]  = w.pos_y;
         p[2]  = w.pos_z;
         rad_s = $signed({2'b00, w.sphere_radius});
         case (w.req_type)
            REQ_CLEAR: begin
               n_spheres = '0;
               empty_box();
            end
            REQ_ADD: begin
               if (n_spheres >= MAX_SPHERES) begin
                  r.status = 1'b1;
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     lo = BOX_BITS'(p[k]) - rad_s;
                     hi = BOX_BITS'(p[k]) + rad_s;
                     center_tab[n_spheres][k] = p[k];
                     if (lo < box_lo[k]) box_lo[k] = lo;
                     if (hi > box_hi[k]) box_hi[k] = hi;
                  end
                  radius_tab[n_spheres] = w.sphere_radius;
                  n_spheres++;
               end
            end
            REQ_QUERY: begin
               in_box = 1'b1;
               for (int k = 0; k < 3; k++)
                  if (BOX_BITS'(p[k]) < box_lo[k] || BOX_BITS'(p[k]) > box_hi[k])
                     in_box = 1'b0;
               if (in_box) begin
                  for (i = 0; i < n_spheres && !r.inside_res; i++) begin
                     d2 = dist_sq(p[0], center_tab[i][0]) + dist_sq(p[1], center_tab[i][1])
                        + dist_sq(p[2], center_tab[i][2]);
                     rad = ACC_BITS'(radius_tab[i]);
                     if (d2 <= rad * rad) r.inside_res = 1'b1;
                  end
               end
            end
            default: ;
         endcase
         r.sphere_count = n_spheres;
         return r;
      endfunction

      function void note_word(req_item_type w);
         owed_answers.push_back(answer_for(w));
      endfunction

      task report(string what);
         if (errors < 100) $display("[%0t] result %0d: %s", $time, checked, what);
         errors++;
      endtask

      task check_word(rsp_item_type got);
         rsp_item_type want;
         checked++;
         if (owed_answers.size() == 0) begin
            report($sformatf("result word %h with nothing owed", got));
         end else begin
            want = owed_answers.pop_front();
            if (got.inside_res !== want.inside_res)
               report($sformatf("inside_res %b, want %b", got.inside_res, want.inside_res));
            if (got.status !== want.status)
               report($sformatf("status %b, want %b", got.status, want.status));
            if (got.sphere_count !== want.sphere_count)
               report($sformatf("sphere_count %0d, want %0d",
                                got.sphere_count, want.sphere_count));
         end
      endtask

      function int pending();
         return owed_answers.size();
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   sphere_union_tracker sb = new();

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int words_sent    = 0;
   int stuck_cycles  = 0;

   point_in_sphere_union u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver back-pressure, drawn fresh every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result checking and the no-progress counter, both on pre-edge values
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) sb.check_word(rsp_data);
   end

   // watchdog: nothing moved for too long
   initial begin
      do @(posedge clock); while (stuck_cycles < STUCK_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   function automatic req_item_type mk_word(logic [1:0] t, int x, int y, int z, int r);
      req_item_type w;
      w.req_type      = t;
      w.pos_x         = coord_type'(x);
      w.pos_y         = coord_type'(y);
      w.pos_z         = coord_type'(z);
      w.sphere_radius = r[RAD_BITS-1:0];
      return w;
   endfunction

   // any code, any bits: exercises every field bit and the unused code
   function automatic req_item_type noise_word();
      return mk_word(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
   endfunction

   // new sphere near a cluster base, mostly small radii, some huge or degenerate
   function automatic req_item_type sphere_word(int bx, int by, int bz);
      int pick;
      int rad;
      pick = $urandom_range(0, 19);
      if (pick < 12)      rad = $urandom_range(0, 6000);
      else if (pick < 17) rad = $urandom_range(0, RAD_MAX);
      else if (pick < 18) rad = 0;
      else                rad = RAD_MAX;
      return mk_word(REQ_ADD, bx + $urandom_range(0, 20000) - 10000,
                     by + $urandom_range(0, 20000) - 10000,
                     bz + $urandom_range(0, 20000) - 10000, rad);
   endfunction

   // query aimed at a stored sphere: center, surface, just past it, inside, nearby, anywhere
   function automatic req_item_type probe_word();
      int pt[3];
      int rad;
      int pick;
      int axis;
      if (sb.n_spheres == 0)
         return mk_word(REQ_QUERY, $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(0, sb.n_spheres - 1);
      for (int k = 0; k < 3; k++) pt[k] = int'(sb.center_tab[pick][k]);
      rad  = int'(sb.radius_tab[pick]);
      axis = $urandom_range(0, 2);
      case ($urandom_range(0, 5))
         0: ;
         1: pt[axis] += $urandom_range(0, 1) ? rad : -rad;
         2: pt[axis] += $urandom_range(0, 1) ? rad + 1 : -rad - 1;
         3: for (int k = 0; k < 3; k++) pt[k] += $urandom_range(0, rad) - rad / 2;
         4: for (int k = 0; k < 3; k++) pt[k] += $urandom_range(0, 16000) - 8000;
         default: for (int k = 0; k < 3; k++) pt[k] = $urandom;
      endcase
      return mk_word(REQ_QUERY, pt[0], pt[1], pt[2], $urandom);
   endfunction

   // one word across the request channel; valid stays up between back-to-back words
   task automatic send_word(input req_item_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(w);
      words_sent++;
   endtask

   task automatic run_directed();
      // empty table answers no, unused code is a no-op
      send_word(mk_word(REQ_QUERY, 0, 0, 0, 0));
      send_word(mk_word(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom));
      // spheres at opposite corners of the coordinate range
      send_word(mk_word(REQ_ADD, COORD_MAX, COORD_MAX, COORD_MAX, 0));
      send_word(mk_word(REQ_ADD, COORD_MIN, COORD_MIN, COORD_MIN, RAD_MAX));
      send_word(mk_word(REQ_QUERY, COORD_MAX, COORD_MAX, COORD_MAX, 0));
      send_word(mk_word(REQ_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 0));
      send_word(mk_word(REQ_QUERY, 0, 0, 0, 0));
      // on the surface of the huge sphere, then one step past it
      send_word(mk_word(REQ_QUERY, -1, COORD_MIN, COORD_MIN, 0));
      send_word(mk_word(REQ_QUERY, 0, COORD_MIN, COORD_MIN, 0));
      send_word(mk_word(REQ_CLEAR, 0, 0, 0, 0));
      send_word(mk_word(REQ_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, 0));
      // small sphere: surface points, box-face rejects, in the box just inside and just outside the sphere
      send_word(mk_word(REQ_ADD, 100, -200, 300, 50));
      send_word(mk_word(REQ_QUERY, 150, -200, 300, 0));
      send_word(mk_word(REQ_QUERY, 151, -200, 300, 0));
      send_word(mk_word(REQ_QUERY, 100, -200, 350, 0));
      send_word(mk_word(REQ_QUERY, 100, -251, 300, 0));
      send_word(mk_word(REQ_QUERY, 135, -165, 300, 0));
      send_word(mk_word(REQ_QUERY, 136, -164, 300, 0));
      // all-ones word, then a clear with all-ones fields and a zero-radius sphere at the origin
      send_word('1);
      send_word(mk_word(REQ_CLEAR, -1, -1, -1, RAD_MAX));
      send_word(mk_word(REQ_ADD, 0, 0, 0, 0));
      send_word(mk_word(REQ_QUERY, 0, 0, 0, RAD_MAX));
      send_word(mk_word(REQ_QUERY, 1, 0, 0, 0));
   endtask

   // clusters of spheres followed by probes, with some stray words mixed in
   task automatic run_mix(int n_words);
      int goal;
      int bx;
      int by;
      int bz;
      goal = words_sent + n_words;
      while (words_sent < goal) begin
         if ($urandom_range(99) < 80) begin
            bx = $urandom;
            by = $urandom;
            bz = $urandom;
            if ($urandom_range(99) < 80)
               send_word(mk_word(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
            repeat ($urandom_range(1, 8))
               send_word($urandom_range(99) < 5 ? noise_word() : sphere_word(bx, by, bz));
            repeat ($urandom_range(2, 8))
               send_word($urandom_range(99) < 5 ?
                         mk_word(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom) :
                         probe_word());
         end else begin
            send_word(noise_word());
         end
      end
   endtask

   // fill the table to the top, push past it, then run queries, some of which walk every entry
   task automatic fill_table();
      int i;
      send_word(mk_word(REQ_CLEAR, 0, 0, 0, 0));
      for (i = 0; i < MAX_SPHERES; i++)
         send_word(mk_word(REQ_ADD, i * 1000 - 128000, 5 * i, -7 * i, $urandom_range(0, 400)));
      // both dropped; the huge one would swallow everything if it got in
      send_word(mk_word(REQ_ADD, 0, 0, 0, RAD_MAX));
      send_word(mk_word(REQ_ADD, $urandom, $urandom, $urandom, $urandom));
      // last entry only, then a gap between neighbors, then outside the box
      send_word(mk_word(REQ_QUERY, (MAX_SPHERES - 1) * 1000 - 128000,
                        5 * (MAX_SPHERES - 1), -7 * (MAX_SPHERES - 1), 0));
      i = $urandom_range(0, MAX_SPHERES - 2);
      send_word(mk_word(REQ_QUERY, i * 1000 - 127500, 5 * i, -7 * i, 0));
      send_word(mk_word(REQ_QUERY, 0, 0, 100000, 0));
      send_word(mk_word(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom));
      repeat (6) send_word(probe_word());
      send_word(mk_word(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom));
   endtask

   initial begin
      // slow sender, stalling receiver
      send_idle_pct = 23;
      recv_idle_pct = 87;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_mix(80);
      // roles swapped
      send_idle_pct = 87;
      recv_idle_pct = 23;
      run_mix(80);
      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_table();
      run_mix(80);
      req_valid <= 1'b0;
      // drain, then watch a while for stray result words
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
